FILE: design/crsp_pkg.sv
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared types and constants for the change record stream parser.
// ----------------------------------------------------------------------------
package crsp_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int DIGIT_BITS  = 7;
  localparam int SHIFT_BITS  = 6;
  localparam int POS_BITS    = 48;
  localparam int VAL_OUT     = 48;
  localparam int LEN_OUT     = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 48;
  localparam int KIND_BITS   = 2;
  localparam int TDATA_BITS  = 4 * VAL_OUT + 2 * LEN_OUT;

  localparam logic [CFG_IDX_BITS-1:0] CFG_RECORD_CODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_DEVICE = 2'd1;

  localparam logic [KIND_BITS-1:0] KIND_DONE     = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_BAD_CMD  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TOO_LONG = 2'd2;

  typedef enum logic [3:0] {
    PH_CMD     = 4'd0,
    PH_NUM     = 4'd1,
    PH_DEV     = 4'd2,
    PH_CATLEN  = 4'd3,
    PH_CATDATA = 4'd4,
    PH_CHGLEN  = 4'd5,
    PH_CHGDATA = 4'd6
  } phase_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] stream_byte;
  } step_t;

  typedef struct packed {
    logic [LEN_OUT-1:0]   changes_length;
    logic [VAL_OUT-1:0]   changes_offset;
    logic [LEN_OUT-1:0]   category_length;
    logic [VAL_OUT-1:0]   category_offset;
    logic [VAL_OUT-1:0]   inode_device;
    logic [VAL_OUT-1:0]   inode_number;
    logic [KIND_BITS-1:0] kind;
  } result_t;

endpackage

FILE: design/crsp_in_stage.sv
// ----------------------------------------------------------------------------
// crsp_in_stage
// Input register that holds one accepted stream byte until the parser steps.
// ----------------------------------------------------------------------------
module crsp_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [crsp_pkg::BYTE_BITS-1:0] s_axis_tdata,
  input  logic                          advance,
  output crsp_pkg::step_t               step
);

  logic                           in_valid;
  logic [crsp_pkg::BYTE_BITS-1:0] in_byte;

  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  assign step.valid       = in_valid && advance;
  assign step.stream_byte = in_byte;

endmodule

FILE: design/crsp_parse_core.sv
// ----------------------------------------------------------------------------
// crsp_parse_core
// Parse state machine: command check, varint decode, string skipping and
// record assembly, one byte per step.
// ----------------------------------------------------------------------------
module crsp_parse_core #(
  parameter int VALUE_BITS  = 48,
  parameter int LENGTH_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [crsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [crsp_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  crsp_pkg::step_t                   step,
  output logic                              res_valid,
  output crsp_pkg::result_t                 res
);

  localparam int ACC_BITS = (VALUE_BITS > LENGTH_BITS) ? VALUE_BITS : LENGTH_BITS;
  localparam int CMP_BITS = (VALUE_BITS > crsp_pkg::CFG_DATA_BITS) ?
                            VALUE_BITS : crsp_pkg::CFG_DATA_BITS;
  localparam logic [ACC_BITS-1:0] VAL_MASK = ACC_BITS'({VALUE_BITS{1'b1}});
  localparam logic [ACC_BITS-1:0] LEN_MASK = ACC_BITS'({LENGTH_BITS{1'b1}});
  localparam logic [crsp_pkg::SHIFT_BITS:0] VAL_W = 7'(VALUE_BITS);
  localparam logic [crsp_pkg::SHIFT_BITS:0] LEN_W = 7'(LENGTH_BITS);
  localparam logic [crsp_pkg::SHIFT_BITS:0] DIGIT = 7'(crsp_pkg::DIGIT_BITS);

  logic [crsp_pkg::BYTE_BITS-1:0]      record_code;
  logic [crsp_pkg::CFG_DATA_BITS-1:0]  local_device;

  crsp_pkg::phase_t                    phase, phase_next;
  logic [ACC_BITS-1:0]                 accumulator, accumulator_next;
  logic [crsp_pkg::SHIFT_BITS-1:0]     shift_amount, shift_amount_next;
  logic [LENGTH_BITS-1:0]              bytes_left, bytes_left_next;
  logic [crsp_pkg::POS_BITS-1:0]       position, position_next;
  logic [VALUE_BITS-1:0]               held_number, held_number_next;
  logic [VALUE_BITS-1:0]               held_device, held_device_next;
  logic [crsp_pkg::POS_BITS-1:0]       held_cat_offset, held_cat_offset_next;
  logic [LENGTH_BITS-1:0]              held_cat_length, held_cat_length_next;
  logic [LENGTH_BITS-1:0]              held_chg_length, held_chg_length_next;
  logic                                halted, halted_next;

  logic [crsp_pkg::BYTE_BITS-1:0]      b;
  logic                                is_value;
  logic [ACC_BITS-1:0]                 acc_val;
  logic                                too_long;
  logic [VALUE_BITS-1:0]               v_val;
  logic [LENGTH_BITS-1:0]              v_len;
  logic [LENGTH_BITS-1:0]              left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_code  <= '0;
      local_device <= '0;
    end else if (cfg_write) begin
      if (cfg_index == crsp_pkg::CFG_RECORD_CODE) begin
        record_code <= cfg_data[crsp_pkg::BYTE_BITS-1:0];
      end else if (cfg_index == crsp_pkg::CFG_LOCAL_DEVICE) begin
        local_device <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= crsp_pkg::PH_CMD;
      accumulator     <= '0;
      shift_amount    <= '0;
      bytes_left      <= '0;
      position        <= '0;
      held_number     <= '0;
      held_device     <= '0;
      held_cat_offset <= '0;
      held_cat_length <= '0;
      held_chg_length <= '0;
      halted          <= 1'b0;
    end else begin
      phase           <= phase_next;
      accumulator     <= accumulator_next;
      shift_amount    <= shift_amount_next;
      bytes_left      <= bytes_left_next;
      position        <= position_next;
      held_number     <= held_number_next;
      held_device     <= held_device_next;
      held_cat_offset <= held_cat_offset_next;
      held_cat_length <= held_cat_length_next;
      held_chg_length <= held_chg_length_next;
      halted          <= halted_next;
    end
  end

  assign b        = step.stream_byte;
  assign is_value = (phase == crsp_pkg::PH_NUM) || (phase == crsp_pkg::PH_DEV);
  assign acc_val  = (accumulator | (ACC_BITS'(b[crsp_pkg::DIGIT_BITS-1:0]) << shift_amount))
                    & (is_value ? VAL_MASK : LEN_MASK);
  assign too_long = b[crsp_pkg::BYTE_BITS-1] &&
                    (({1'b0, shift_amount} + DIGIT) >= (is_value ? VAL_W : LEN_W));
  assign v_val    = VALUE_BITS'(acc_val);
  assign v_len    = LENGTH_BITS'(acc_val);
  assign left_dec = bytes_left - LENGTH_BITS'(1);

  always_comb begin
    phase_next           = phase;
    accumulator_next     = accumulator;
    shift_amount_next    = shift_amount;
    bytes_left_next      = bytes_left;
    position_next        = position;
    held_number_next     = held_number;
    held_device_next     = held_device;
    held_cat_offset_next = held_cat_offset;
    held_cat_length_next = held_cat_length;
    held_chg_length_next = held_chg_length;
    halted_next          = halted;
    res_valid            = 1'b0;
    res                  = '0;

    if (step.valid && !halted) begin
      position_next = position + crsp_pkg::POS_BITS'(1);
      unique case (phase)
        crsp_pkg::PH_CMD: begin
          if (b != record_code) begin
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res.kind    = crsp_pkg::KIND_BAD_CMD;
          end else begin
            phase_next        = crsp_pkg::PH_NUM;
            accumulator_next  = '0;
            shift_amount_next = '0;
          end
        end
        crsp_pkg::PH_CATDATA, crsp_pkg::PH_CHGDATA: begin
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            if (phase == crsp_pkg::PH_CATDATA) begin
              phase_next        = crsp_pkg::PH_CHGLEN;
              accumulator_next  = '0;
              shift_amount_next = '0;
            end else begin
              phase_next          = crsp_pkg::PH_CMD;
              res_valid           = 1'b1;
              res.kind            = crsp_pkg::KIND_DONE;
              res.inode_number    = crsp_pkg::VAL_OUT'(held_number);
              res.inode_device    = crsp_pkg::VAL_OUT'(held_device);
              res.category_offset = held_cat_offset;
              res.category_length = crsp_pkg::LEN_OUT'(held_cat_length);
              res.changes_offset  = position_next - crsp_pkg::POS_BITS'(held_chg_length);
              res.changes_length  = crsp_pkg::LEN_OUT'(held_chg_length);
            end
          end
        end
        crsp_pkg::PH_NUM, crsp_pkg::PH_DEV, crsp_pkg::PH_CATLEN, crsp_pkg::PH_CHGLEN: begin
          accumulator_next = acc_val;
          if (b[crsp_pkg::BYTE_BITS-1]) begin
            if (too_long) begin
              halted_next = 1'b1;
              res_valid   = 1'b1;
              res.kind    = crsp_pkg::KIND_TOO_LONG;
            end else begin
              shift_amount_next = shift_amount + crsp_pkg::SHIFT_BITS'(crsp_pkg::DIGIT_BITS);
            end
          end else begin
            accumulator_next  = '0;
            shift_amount_next = '0;
            unique case (phase)
              crsp_pkg::PH_NUM: begin
                held_number_next = v_val;
                if (v_val != '0) begin
                  phase_next = crsp_pkg::PH_DEV;
                end else begin
                  held_device_next = '0;
                  phase_next       = crsp_pkg::PH_CATLEN;
                end
              end
              crsp_pkg::PH_DEV: begin
                held_device_next = (CMP_BITS'(v_val) == CMP_BITS'(local_device)) ? '0 : v_val;
                phase_next       = crsp_pkg::PH_CATLEN;
              end
              crsp_pkg::PH_CATLEN: begin
                held_cat_length_next = v_len;
                held_cat_offset_next = position_next;
                if (v_len == '0) begin
                  phase_next = crsp_pkg::PH_CHGLEN;
                end else begin
                  bytes_left_next = v_len;
                  phase_next      = crsp_pkg::PH_CATDATA;
                end
              end
              default: begin
                held_chg_length_next = v_len;
                if (v_len == '0) begin
                  phase_next          = crsp_pkg::PH_CMD;
                  res_valid           = 1'b1;
                  res.kind            = crsp_pkg::KIND_DONE;
                  res.inode_number    = crsp_pkg::VAL_OUT'(held_number);
                  res.inode_device    = crsp_pkg::VAL_OUT'(held_device);
                  res.category_offset = held_cat_offset;
                  res.category_length = crsp_pkg::LEN_OUT'(held_cat_length);
                  res.changes_offset  = position_next;
                  res.changes_length  = '0;
                end else begin
                  bytes_left_next = v_len;
                  phase_next      = crsp_pkg::PH_CHGDATA;
                end
              end
            endcase
          end
        end
        default: begin
          phase_next = crsp_pkg::PH_CMD;
        end
      endcase
    end
  end

endmodule

FILE: design/crsp_out_stage.sv
// ----------------------------------------------------------------------------
// crsp_out_stage
// Result register that holds one record or error until the sink takes it.
// ----------------------------------------------------------------------------
module crsp_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             res_valid,
  input  crsp_pkg::result_t                res,
  output logic                             advance,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [crsp_pkg::TDATA_BITS-1:0]  m_axis_tdata,
  output logic [crsp_pkg::KIND_BITS-1:0]   m_axis_tuser
);

  logic              out_valid;
  crsp_pkg::result_t out_data;

  assign advance = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_data.kind;
  assign m_axis_tdata  = out_data[$bits(crsp_pkg::result_t)-1:crsp_pkg::KIND_BITS];

endmodule

FILE: design/change_record_stream_parser_top.sv
// ----------------------------------------------------------------------------
// change_record_stream_parser_top
// Byte-stream parser for length-prefixed change records with varint fields.
// ----------------------------------------------------------------------------
// Path: a byte waits in the input register, the parse state machine steps on it, and the result is registered.
// Throughput: one byte per cycle while the sink takes results; the parse state machine steps at most once a cycle.
// Reset: synchronous; clears the parse state, halt flag, position and both
// configuration registers (record code and local device read as zero).
module change_record_stream_parser_top #(
  parameter int VALUE_BITS  = 48,
  parameter int LENGTH_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_axis_tdata: stream_byte [7:0].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [crsp_pkg::BYTE_BITS-1:0]     s_axis_tdata,
  // m_axis_tdata: inode_number [47:0], inode_device [95:48],
  // category_offset [143:96], category_length [175:144],
  // changes_offset [223:176], changes_length [255:224].
  // m_axis_tuser: kind [1:0].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [crsp_pkg::TDATA_BITS-1:0]    m_axis_tdata,
  output logic [crsp_pkg::KIND_BITS-1:0]     m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [crsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic              advance;
  crsp_pkg::step_t   step;
  logic              res_valid;
  crsp_pkg::result_t res;

  assign cfg_ready = 1'b1;

  crsp_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (advance),
    .step          (step)
  );

  crsp_parse_core #(
    .VALUE_BITS  (VALUE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  crsp_out_stage u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: design/crsp_checker.sv
// ----------------------------------------------------------------------------
// crsp_checker
// Port-level checks on the result stream of the change record parser.
// ----------------------------------------------------------------------------
module crsp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [crsp_pkg::TDATA_BITS-1:0]  m_axis_tdata,
  input logic [crsp_pkg::KIND_BITS-1:0]   m_axis_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != crsp_pkg::KIND_DONE |-> m_axis_tdata == '0)
    else $error("error result carries nonzero fields");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == crsp_pkg::KIND_DONE ||
                       m_axis_tuser == crsp_pkg::KIND_BAD_CMD ||
                       m_axis_tuser == crsp_pkg::KIND_TOO_LONG))
    else $error("illegal result kind");

  a_halt_after_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser != crsp_pkg::KIND_DONE
    |=> !m_axis_tvalid)
    else $error("result after error before reset");

endmodule

bind change_record_stream_parser_top crsp_checker u_crsp_checker (.*);
